FILE: rtl/tach_pkg.sv
// Package for the pulse tachometer: shared widths, constants, codes and types.
// Used by every module in rtl/.
package tach_pkg;

    localparam int TIME_BITS_DEF   = 32;
    localparam int REJECT_BITS_DEF = 16;

    localparam int PERIOD_W = 32;
    localparam int SPEED_W  = 30;
    localparam int REJ_W    = 16;
    localparam int PPR_W    = 16;
    localparam int DEB_W    = 16;
    localparam int STALL_W  = 32;
    localparam int DEN_W    = SPEED_W + PPR_W;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [SPEED_W-1:0] SPEED_NUM = SPEED_W'(600000000);

    localparam logic [1:0]         EDGE_MODE_RST = 2'd0;
    localparam logic [PPR_W-1:0]   PPR_RST       = PPR_W'(1);
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = DEB_W'(75);
    localparam logic [STALL_W-1:0] STALL_RST     = STALL_W'(500000);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int DIV_CNT_W = $clog2(SPEED_W);

    // edge_mode codes; the unused code behaves as rising
    localparam logic [1:0] EDGE_RISE = 2'd0;
    localparam logic [1:0] EDGE_FALL = 2'd1;
    localparam logic [1:0] EDGE_DUAL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL     = 2'd3;

    // snapshot of the status taken at a read request
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                valid;
        logic                stalled;
        logic [REJ_W-1:0]    rejected;
        logic                zero;
        logic                big;
    } t_qent;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

FILE: rtl/tach_front.sv
// Front end: tick counter, edge detect, debounce, period capture and status snapshot.
// Depends on tach_pkg.
module tach_front #(
    parameter int TIME_BITS   = tach_pkg::TIME_BITS_DEF,
    parameter int REJECT_BITS = tach_pkg::REJECT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic                     i_pin_level,
    input  logic                     i_read_request,
    input  logic [1:0]               i_edge_mode,
    input  logic [tach_pkg::DEB_W-1:0]   i_debounce,
    input  logic [tach_pkg::STALL_W-1:0] i_stall,
    output logic                     o_push,
    output tach_pkg::t_qent          o_ent
);
    import tach_pkg::*;

    localparam int CW = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;
    localparam int RW = (REJECT_BITS > REJ_W) ? REJECT_BITS : REJ_W;

    logic [TIME_BITS-1:0]   r_time, r_last, r_period;
    logic [TIME_BITS-1:0]   n_last, n_period;
    logic [REJECT_BITS-1:0] r_rej, n_rej;
    logic                   r_seen, n_seen, r_prev, r_big, n_big;

    logic [TIME_BITS-1:0] interval, since_last;
    logic [CW-1:0]        interval_x, since_x, period_x;
    logic [RW-1:0]        rej_x;
    logic                 rise, fall, is_edge, edge_ok, timeout, valid;

    always_comb begin
        rise = i_pin_level & ~r_prev;
        fall = ~i_pin_level & r_prev;
        case (i_edge_mode)
            EDGE_FALL: is_edge = fall;
            EDGE_DUAL: is_edge = rise | fall;
            default:   is_edge = rise;
        endcase

        interval   = r_time - r_last;
        interval_x = CW'(interval);
        edge_ok    = is_edge & (~r_seen | (interval >= TIME_BITS'(i_debounce)));

        n_rej = r_rej;
        if (is_edge && !edge_ok && (r_rej != {REJECT_BITS{1'b1}})) begin
            n_rej = r_rej + 1'b1;
        end
        n_seen   = r_seen | edge_ok;
        n_period = edge_ok ? interval : r_period;
        n_last   = edge_ok ? r_time : r_last;
        n_big    = edge_ok ? (interval_x > CW'(SPEED_NUM)) : r_big;

        since_last = edge_ok ? '0 : interval;
        since_x    = CW'(since_last);
        timeout    = n_seen & (since_x >= CW'(i_stall));
        valid      = n_seen & ~timeout;
        period_x   = CW'(n_period);
        rej_x      = RW'(n_rej);

        o_push         = i_fire & i_read_request;
        o_ent.period   = valid ? period_x[PERIOD_W-1:0] : '0;
        o_ent.valid    = valid;
        o_ent.stalled  = timeout;
        o_ent.rejected = rej_x[REJ_W-1:0];
        o_ent.zero     = (n_period == '0);
        o_ent.big      = n_big;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time   <= '0;
            r_last   <= '0;
            r_period <= '0;
            r_rej    <= '0;
            r_seen   <= 1'b0;
            r_prev   <= 1'b0;
            r_big    <= 1'b0;
        end else if (i_fire) begin
            r_time   <= r_time + 1'b1;
            r_last   <= n_last;
            r_period <= n_period;
            r_rej    <= n_rej;
            r_seen   <= n_seen;
            r_prev   <= i_pin_level;
            r_big    <= n_big;
        end
    end

endmodule

FILE: rtl/tach_queue.sv
// Short queue of status snapshots between the front end and the speed divider.
// Depends on tach_pkg.
module tach_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tach_pkg::t_qent i_ent,
    input  logic            i_pop,
    output tach_pkg::t_qent o_ent,
    output tach_pkg::t_qstat o_stat
);
    import tach_pkg::*;

    t_qent               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] res;
        res = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
        return res;
    endfunction

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_ent        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_stat.full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow push");
`endif

endmodule

FILE: rtl/tach_back.sv
// Back end: period times pulses per revolution, then a bit-serial restoring divider
// for speed x10, and the output register. Depends on tach_pkg.
module tach_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tach_pkg::t_qent            i_ent,
    input  tach_pkg::t_qstat           i_qstat,
    output logic                       o_pop,
    input  logic [tach_pkg::PPR_W-1:0] i_ppr,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [tach_pkg::PERIOD_W-1:0] o_period_time,
    output logic [tach_pkg::SPEED_W-1:0]  o_speed_x10,
    output logic                       o_speed_valid,
    output logic                       o_stalled,
    output logic [tach_pkg::REJ_W-1:0] o_rejected_total
);
    import tach_pkg::*;

    t_back_state r_state, n_state;
    t_qent       r_ent;

    logic [DEN_W-1:0]     r_den;
    logic [SPEED_W-1:0]   r_num, r_rem, r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    logic [PERIOD_W-1:0]  r_o_period;
    logic [SPEED_W-1:0]   r_o_speed;
    logic                 r_o_valid, r_o_stalled;
    logic [REJ_W-1:0]     r_o_rej;

    logic                 load_out, special, ge;
    logic [PPR_W-1:0]     ppr_eff;
    logic [SPEED_W:0]     trial;
    logic [SPEED_W:0]     diff;

    always_comb begin
        ppr_eff = (i_ppr == '0) ? PPR_W'(1) : i_ppr;
        special = ~r_ent.valid | r_ent.zero | r_ent.big;
        trial   = {r_rem, r_num[SPEED_W-1]};
        ge      = (DEN_W'(trial) >= r_den);
        diff    = trial - r_den[SPEED_W:0];
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = special ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == DIV_CNT_W'(SPEED_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_ent;
        end
        case (r_state)
            ST_MUL: begin
                r_den <= DEN_W'(r_ent.period[SPEED_W-1:0]) * DEN_W'(ppr_eff);
                r_num <= SPEED_NUM;
                r_rem <= '0;
                r_cnt <= '0;
                if (!r_ent.valid || r_ent.big) begin
                    r_quo <= '0;
                end else begin
                    r_quo <= SPEED_NUM;
                end
            end
            ST_DIV: begin
                r_num <= {r_num[SPEED_W-2:0], 1'b0};
                r_rem <= ge ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
                r_quo <= {r_quo[SPEED_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
        if (load_out) begin
            r_o_period  <= r_ent.period;
            r_o_speed   <= r_quo;
            r_o_valid   <= r_ent.valid;
            r_o_stalled <= r_ent.stalled;
            r_o_rej     <= r_ent.rejected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_period_time    = r_o_period;
    assign o_speed_x10      = r_o_speed;
    assign o_speed_valid    = r_o_valid;
    assign o_stalled        = r_o_stalled;
    assign o_rejected_total = r_o_rej;

endmodule

FILE: rtl/pulse_tachometer.sv
// Pulse tachometer top level: configuration registers, front end, snapshot queue, divider.
// Depends on tach_pkg, tach_front, tach_queue, tach_back.
//
//   channel | handshake                  | payload
//   in      | i_in_valid / o_in_ready    | i_pin_level, i_read_request (one tick each)
//   out     | o_out_valid / i_out_ready  | o_period_time, o_speed_x10, o_speed_valid,
//           |                            | o_stalled, o_rejected_total
//   cfg     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A tick is taken whenever the two-entry snapshot queue has room. The divider serves
// one read request at a time: pop, multiply, 30 divide steps (one quotient bit a
// cycle), output load; invalid, zero-period or saturated cases skip the steps.
// Input stalls only when the queue is full; the output register holds until taken.
// Synchronous active-low reset clears control state, not data; no clearing pass is needed.
module pulse_tachometer #(
    parameter int TIME_BITS   = tach_pkg::TIME_BITS_DEF,
    parameter int REJECT_BITS = tach_pkg::REJECT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_pin_level,
    input  logic                           i_read_request,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tach_pkg::PERIOD_W-1:0]  o_period_time,
    output logic [tach_pkg::SPEED_W-1:0]   o_speed_x10,
    output logic                           o_speed_valid,
    output logic                           o_stalled,
    output logic [tach_pkg::REJ_W-1:0]     o_rejected_total,
    input  logic                           i_cfg_we,
    input  logic [tach_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tach_pkg::CFG_W-1:0]     i_cfg_data
);
    import tach_pkg::*;

    logic [1:0]         r_edge_mode;
    logic [PPR_W-1:0]   r_ppr;
    logic [DEB_W-1:0]   r_debounce;
    logic [STALL_W-1:0] r_stall;

    logic   fire, push, pop;
    t_qent  front_ent, head_ent;
    t_qstat qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_mode <= EDGE_MODE_RST;
            r_ppr       <= PPR_RST;
            r_debounce  <= DEBOUNCE_RST;
            r_stall     <= STALL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EDGE_MODE: r_edge_mode <= i_cfg_data[1:0];
                CFG_PPR:       r_ppr       <= i_cfg_data[PPR_W-1:0];
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_data[DEB_W-1:0];
                CFG_STALL:     r_stall     <= i_cfg_data[STALL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = ~qstat.full;
    assign fire       = i_in_valid & o_in_ready;

    tach_front #(
        .TIME_BITS   (TIME_BITS),
        .REJECT_BITS (REJECT_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_pin_level    (i_pin_level),
        .i_read_request (i_read_request),
        .i_edge_mode    (r_edge_mode),
        .i_debounce     (r_debounce),
        .i_stall        (r_stall),
        .o_push         (push),
        .o_ent          (front_ent)
    );

    tach_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (front_ent),
        .i_pop   (pop),
        .o_ent   (head_ent),
        .o_stat  (qstat)
    );

    tach_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ent            (head_ent),
        .i_qstat          (qstat),
        .o_pop            (pop),
        .i_ppr            (r_ppr),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_period_time    (o_period_time),
        .o_speed_x10      (o_speed_x10),
        .o_speed_valid    (o_speed_valid),
        .o_stalled        (o_stalled),
        .o_rejected_total (o_rejected_total)
    );

endmodule
